// ----- rtl/pfg3d_pkg.sv -----
// Shared constants and types for the 3D field gather core.
// No dependencies; imported by pfg3d_div, pic_field_gather_3d_core and the testbench.
package pfg3d_pkg;

   localparam int MaxNodes  = 16;
   localparam int NodeBits  = 4;
   localparam int FracBits  = 16;
   localparam logic [16:0] OneQ = 17'h10000;

   typedef enum logic [2:0] {
      REG_NODES_X = 3'd0,
      REG_NODES_Y = 3'd1,
      REG_NODES_Z = 3'd2,
      REG_CELL_X  = 3'd3,
      REG_CELL_Y  = 3'd4,
      REG_CELL_Z  = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic        start;
      logic [31:0] rem;
      logic [31:0] dsr;
      logic [31:0] divisor;
      logic [5:0]  steps;
   } div_req_type;

endpackage

// ----- rtl/pic_field_gather_3d_core.sv -----
// Field gather core: node store, home-cell search, shape weights, weighted sum.
// Depends on pfg3d_pkg and pfg3d_div.
//
//   channel  | handshake            | payload
//   request  | start / busy         | req_cmd, req_field_sel, req_node_addr, req_val_*,
//            |                      | req_pos_*, req_half_*
//   response | rsp_strobe (1 cycle) | rsp_gathered_*, rsp_out_of_grid, rsp_shape_error
//   config   | psel/penable/pwrite  | paddr, pwdata, prdata, pready
//
// A node write gives no beat. A gather runs the home-cell division (three 32-step
// divisions on the shared divider), then up to 12 shape edges (17-step division
// each), then reads each neighborhood node through the single grid memory port.
// Reset is synchronous; no clearing pass, grid contents are undefined until written.
// The receiver cannot stall: each result beat is shown for exactly one cycle.
module pic_field_gather_3d_core import pfg3d_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_cmd,
   input  logic               req_field_sel,
   input  logic [11:0]        req_node_addr,
   input  logic signed [31:0] req_val_x,
   input  logic signed [31:0] req_val_y,
   input  logic signed [31:0] req_val_z,
   input  logic [31:0]        req_pos_x,
   input  logic [31:0]        req_pos_y,
   input  logic [31:0]        req_pos_z,
   input  logic [31:0]        req_half_x,
   input  logic [31:0]        req_half_y,
   input  logic [31:0]        req_half_z,
   output logic               rsp_strobe,
   output logic signed [31:0] rsp_gathered_x,
   output logic signed [31:0] rsp_gathered_y,
   output logic signed [31:0] rsp_gathered_z,
   output logic               rsp_out_of_grid,
   output logic               rsp_shape_error,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [4:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b00000000001,
      S_HOME      = 11'b00000000010,
      S_HOME_WAIT = 11'b00000000100,
      S_SETUP     = 11'b00000001000,
      S_EDGE_T    = 11'b00000010000,
      S_EDGE_CLS  = 11'b00000100000,
      S_EDGE_WAIT = 11'b00001000000,
      S_EDGE_MASS = 11'b00010000000,
      S_ACC       = 11'b00100000000,
      S_DRAIN     = 11'b01000000000,
      S_FIN       = 11'b10000000000
   } state_type;

   // ---------------- configuration ----------------
   logic [4:0]  ncount_ff [3];
   logic [31:0] cellreg_ff [3];
   logic        cfg_wr;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            ncount_ff[a]  <= 5'd10;
            cellreg_ff[a] <= 32'd65536;
         end
      end else if (cfg_wr) begin
         unique case (paddr[4:2])
            REG_NODES_X: ncount_ff[0]  <= pwdata[4:0];
            REG_NODES_Y: ncount_ff[1]  <= pwdata[4:0];
            REG_NODES_Z: ncount_ff[2]  <= pwdata[4:0];
            REG_CELL_X:  cellreg_ff[0] <= pwdata;
            REG_CELL_Y:  cellreg_ff[1] <= pwdata;
            REG_CELL_Z:  cellreg_ff[2] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_NODES_X: prdata = {27'd0, ncount_ff[0]};
         REG_NODES_Y: prdata = {27'd0, ncount_ff[1]};
         REG_NODES_Z: prdata = {27'd0, ncount_ff[2]};
         REG_CELL_X:  prdata = cellreg_ff[0];
         REG_CELL_Y:  prdata = cellreg_ff[1];
         REG_CELL_Z:  prdata = cellreg_ff[2];
         default:     prdata = '0;
      endcase
   end

   // ---------------- grid memory ----------------
   logic [95:0] grid_mem [8192];
   logic [95:0] mem_q_ff;
   logic [12:0] rd_addr;
   logic        accept, wr_node;

   assign accept  = start & ~busy;
   assign wr_node = accept & ~req_cmd;

   always_ff @(posedge clock) begin
      if (wr_node) begin
         grid_mem[{req_field_sel, req_node_addr}] <= {req_val_z, req_val_y, req_val_x};
      end
      mem_q_ff <= grid_mem[rd_addr];
   end

   // ---------------- control ----------------
   state_type   state_ff, state_in;
   logic [31:0] pos_ff [3];
   logic [31:0] half_ff [3];
   logic [31:0] cell_ff [3];
   logic [4:0]  cnt_ff [3];
   logic [4:0]  home_ff [3];
   logic [3:0]  lo_ff [3];
   logic [1:0]  n_ff [3];
   logic [16:0] mass_ff [3][4];
   logic [1:0]  axis_ff;
   logic [1:0]  edge_ff;
   logic [36:0] t_ff;
   logic        minus_ff;
   logic [16:0] r_ff;
   logic [1:0]  ci_ff, cj_ff, ck_ff;
   logic        sel_ff, oog_ff, serr_ff;

   div_req_type div_req;
   logic        div_done;
   logic [31:0] div_quot;

   pfg3d_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .done  (div_done),
      .quot  (div_quot)
   );

   // setup: neighborhood bounds per axis
   logic [3:0] su_lo [3];
   logic [1:0] su_n [3];
   logic       su_empty [3];
   logic       su_oog, su_serr;

   always_comb begin
      logic [5:0] lo6, hi6, hp1, cm1;
      su_oog  = 1'b0;
      su_serr = 1'b0;
      for (int a = 0; a < 3; a++) begin
         lo6 = (home_ff[a] == 5'd0) ? 6'd0 : {1'b0, home_ff[a]} - 6'd1;
         hp1 = {1'b0, home_ff[a]} + 6'd1;
         cm1 = {1'b0, cnt_ff[a]} - 6'd1;
         hi6 = (hp1 < {1'b0, cnt_ff[a]}) ? hp1 : cm1;
         su_empty[a] = (cnt_ff[a] == 5'd0) || (lo6 > hi6);
         su_lo[a] = lo6[3:0];
         su_n[a]  = 2'(hi6 - lo6 + 6'd1);
         if (home_ff[a] >= cnt_ff[a]) su_oog = 1'b1;
         if (half_ff[a] > cell_ff[a]) su_serr = 1'b1;
      end
   end

   // edge classification
   logic [38:0] tph;
   logic [32:0] xph;
   logic [31:0] cls_x, cls_h;
   logic        c_zero, c_le, c_lt;
   logic [31:0] s_a, s_b;

   assign cls_x  = pos_ff[axis_ff];
   assign cls_h  = half_ff[axis_ff];
   assign tph    = {2'b0, t_ff} + {7'd0, cls_h};
   assign xph    = {1'b0, cls_x} + {1'b0, cls_h};
   assign c_zero = tph <= {7'd0, cls_x};
   assign c_le   = t_ff <= {5'd0, cls_x};
   assign c_lt   = t_ff < {4'd0, xph};
   assign s_a    = 32'(tph - {7'd0, cls_x});
   assign s_b    = 32'({6'd0, xph} - {2'b0, t_ff});

   logic [4:0]  edge_idx;
   logic [33:0] rsq;
   assign edge_idx = {1'b0, lo_ff[axis_ff]} + {3'd0, edge_ff};
   assign rsq      = {17'd0, r_ff} * {17'd0, r_ff};

   function automatic logic [16:0] axis_w(input logic [16:0] hi, input logic [16:0] lo);
      return (hi > lo) ? 17'(hi - lo) : 17'd0;
   endfunction

   logic [16:0] wx, wy, wz;
   assign wx = axis_w(mass_ff[0][ci_ff + 2'd1], mass_ff[0][ci_ff]);
   assign wy = axis_w(mass_ff[1][cj_ff + 2'd1], mass_ff[1][cj_ff]);
   assign wz = axis_w(mass_ff[2][ck_ff + 2'd1], mass_ff[2][ck_ff]);

   assign rd_addr = {sel_ff, lo_ff[0] + {2'd0, ci_ff}, lo_ff[1] + {2'd0, cj_ff},
                     lo_ff[2] + {2'd0, ck_ff}};

   logic acc_last, edge_last;
   assign acc_last  = (ci_ff == n_ff[0] - 2'd1) && (cj_ff == n_ff[1] - 2'd1) &&
                      (ck_ff == n_ff[2] - 2'd1);
   assign edge_last = (edge_ff == n_ff[axis_ff]);

   // pipeline
   logic        v1_ff, v2_ff, v3_ff;
   logic [32:0] p1_ff;
   logic [16:0] wz1_ff;
   logic [33:0] p2_ff;
   logic [95:0] d2_ff;
   logic signed [49:0] prod_ff [3];
   logic signed [37:0] sum_ff [3];
   logic        issue;

   assign issue = (state_ff == S_ACC);

   always_comb begin
      state_in = state_ff;
      div_req  = '0;
      unique case (state_ff)
         S_IDLE:
            if (accept && req_cmd) state_in = S_HOME;
         S_HOME: begin
            div_req.start   = 1'b1;
            div_req.rem     = '0;
            div_req.dsr     = pos_ff[axis_ff];
            div_req.divisor = cell_ff[axis_ff];
            div_req.steps   = 6'd32;
            state_in = S_HOME_WAIT;
         end
         S_HOME_WAIT:
            if (div_done) state_in = (axis_ff == 2'd2) ? S_SETUP : S_HOME;
         S_SETUP:
            if (su_serr || su_empty[0] || su_empty[1] || su_empty[2]) state_in = S_FIN;
            else state_in = S_EDGE_T;
         S_EDGE_T:
            state_in = S_EDGE_CLS;
         S_EDGE_CLS: begin
            if (c_zero || !c_lt) begin
               if (!edge_last) state_in = S_EDGE_T;
               else state_in = (axis_ff == 2'd2) ? S_ACC : S_EDGE_T;
            end else begin
               div_req.start   = 1'b1;
               div_req.rem     = {1'b0, (c_le ? s_a[31:1] : s_b[31:1])};
               div_req.dsr     = {(c_le ? s_a[0] : s_b[0]), 31'd0};
               div_req.divisor = cls_h;
               div_req.steps   = 6'd17;
               state_in = S_EDGE_WAIT;
            end
         end
         S_EDGE_WAIT:
            if (div_done) state_in = S_EDGE_MASS;
         S_EDGE_MASS:
            if (!edge_last) state_in = S_EDGE_T;
            else state_in = (axis_ff == 2'd2) ? S_ACC : S_EDGE_T;
         S_ACC:
            if (acc_last) state_in = S_DRAIN;
         S_DRAIN:
            if (!v1_ff && !v2_ff && !v3_ff) state_in = S_FIN;
         S_FIN:
            state_in = S_IDLE;
         default:
            state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath of the sequencer
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE:
            if (accept && req_cmd) begin
               pos_ff[0]  <= req_pos_x;
               pos_ff[1]  <= req_pos_y;
               pos_ff[2]  <= req_pos_z;
               half_ff[0] <= (req_half_x == '0) ? 32'd1 : req_half_x;
               half_ff[1] <= (req_half_y == '0) ? 32'd1 : req_half_y;
               half_ff[2] <= (req_half_z == '0) ? 32'd1 : req_half_z;
               for (int a = 0; a < 3; a++) begin
                  cell_ff[a] <= (cellreg_ff[a] == '0) ? 32'd1 : cellreg_ff[a];
                  cnt_ff[a]  <= (ncount_ff[a] > 5'(MaxNodes)) ? 5'(MaxNodes) : ncount_ff[a];
               end
               sel_ff  <= req_field_sel;
               axis_ff <= 2'd0;
            end
         S_HOME_WAIT:
            if (div_done) begin
               // saturate: any home past 31 is already off every grid
               home_ff[axis_ff] <= (|div_quot[31:5]) ? 5'd31 : div_quot[4:0];
               axis_ff <= (axis_ff == 2'd2) ? 2'd0 : axis_ff + 2'd1;
            end
         S_SETUP: begin
            oog_ff  <= su_oog;
            serr_ff <= su_serr;
            for (int a = 0; a < 3; a++) begin
               lo_ff[a] <= su_lo[a];
               n_ff[a]  <= su_n[a];
            end
            axis_ff <= 2'd0;
            edge_ff <= 2'd0;
         end
         S_EDGE_T:
            t_ff <= 37'({32'd0, edge_idx} * {5'd0, cell_ff[axis_ff]});
         S_EDGE_CLS: begin
            minus_ff <= ~c_le;
            if (c_zero || !c_lt) begin
               mass_ff[axis_ff][edge_ff] <= c_zero ? 17'd0 : OneQ;
               if (edge_last) begin
                  axis_ff <= axis_ff + 2'd1;
                  edge_ff <= 2'd0;
               end else begin
                  edge_ff <= edge_ff + 2'd1;
               end
            end
         end
         S_EDGE_WAIT:
            if (div_done) r_ff <= div_quot[16:0];
         S_EDGE_MASS: begin
            mass_ff[axis_ff][edge_ff] <= minus_ff ? 17'(OneQ - {1'b0, rsq[32:17]})
                                                  : {1'b0, rsq[32:17]};
            if (edge_last) begin
               axis_ff <= axis_ff + 2'd1;
               edge_ff <= 2'd0;
            end else begin
               edge_ff <= edge_ff + 2'd1;
            end
         end
         default: ;
      endcase
   end

   // node walk counters
   always_ff @(posedge clock) begin
      if (state_ff == S_SETUP) begin
         ci_ff <= 2'd0;
         cj_ff <= 2'd0;
         ck_ff <= 2'd0;
      end else if (issue && !acc_last) begin
         if (ck_ff != n_ff[2] - 2'd1) begin
            ck_ff <= ck_ff + 2'd1;
         end else begin
            ck_ff <= 2'd0;
            if (cj_ff != n_ff[1] - 2'd1) begin
               cj_ff <= cj_ff + 2'd1;
            end else begin
               cj_ff <= 2'd0;
               ci_ff <= ci_ff + 2'd1;
            end
         end
      end
   end

   // weight and accumulate pipeline
   logic [16:0] w3;
   assign w3 = p2_ff[32:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      p1_ff  <= 33'({17'd0, wx} * {17'd0, wy});
      wz1_ff <= wz;
      p2_ff  <= {17'd0, p1_ff[32:16]} * {17'd0, wz1_ff};
      d2_ff  <= mem_q_ff;
      for (int c = 0; c < 3; c++) begin
         prod_ff[c] <= 50'($signed(d2_ff[32*c +: 32]) * $signed({1'b0, w3}));
      end
      if (accept && req_cmd) begin
         for (int c = 0; c < 3; c++) sum_ff[c] <= '0;
      end else if (v3_ff) begin
         for (int c = 0; c < 3; c++) begin
            // truncate toward zero
            sum_ff[c] <= sum_ff[c] + 38'((prod_ff[c] +
                         (prod_ff[c][49] ? 50'sd65535 : 50'sd0)) >>> FracBits);
         end
      end
   end

   // result beat
   logic        strobe_ff;
   logic [31:0] out_ff [3];
   logic        out_oog_ff, out_serr_ff;

   function automatic logic [31:0] sat32(input logic signed [37:0] s);
      if (s > 38'sd2147483647) return 32'h7FFFFFFF;
      if (s < -38'sd2147483648) return 32'h80000000;
      return s[31:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= (state_ff == S_FIN);
      end
      if (state_ff == S_FIN) begin
         for (int c = 0; c < 3; c++) out_ff[c] <= serr_ff ? 32'd0 : sat32(sum_ff[c]);
         out_oog_ff  <= oog_ff;
         out_serr_ff <= serr_ff;
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_gathered_x  = out_ff[0];
   assign rsp_gathered_y  = out_ff[1];
   assign rsp_gathered_z  = out_ff[2];
   assign rsp_out_of_grid = out_oog_ff;
   assign rsp_shape_error = out_serr_ff;

endmodule

// ----- rtl/pfg3d_div.sv -----
// Restoring divider, one quotient bit per cycle, preloadable remainder.
// Depends on pfg3d_pkg (div_req_type).
module pfg3d_div import pfg3d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type req,
   output logic        done,
   output logic [31:0] quot
);

   logic [31:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic [31:0] div_ff, div_in;
   logic [31:0] quot_ff, quot_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in;
   logic        done_ff, done_in;
   logic [32:0] trial;
   logic        ge;

   assign trial = {rem_ff, dsr_ff[31]};
   assign ge    = trial >= {1'b0, div_ff};

   always_comb begin
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      div_in  = div_ff;
      quot_in = quot_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (req.start) begin
         rem_in  = req.rem;
         dsr_in  = req.dsr;
         div_in  = req.divisor;
         quot_in = '0;
         cnt_in  = req.steps;
         run_in  = 1'b1;
      end else if (run_ff) begin
         rem_in  = ge ? 32'(trial - {1'b0, div_ff}) : trial[31:0];
         dsr_in  = {dsr_ff[30:0], 1'b0};
         quot_in = {quot_ff[30:0], ge};
         cnt_in  = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
      div_ff  <= div_in;
      quot_ff <= quot_in;
      cnt_ff  <= cnt_in;
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule

// ----- bench/tb.sv -----
// Testbench for pic_field_gather_3d_core: node writes and field gathers, with a
// self-contained predictor and a scoreboard of gather results. Needs pfg3d_pkg.
`timescale 1ns / 1ps

module tb import pfg3d_pkg::*; ();

   localparam int StoreDepth = 4096;
   localparam int FillSpan   = 4;
   localparam int WatchLimit = 20000;
   localparam logic CmdWrite  = 1'b0;
   localparam logic CmdGather = 1'b1;
   localparam logic SelElec   = 1'b0;
   localparam logic SelMag    = 1'b1;

   typedef struct {
      logic signed [31:0] gx, gy, gz;
      logic               oog, serr;
   } gather_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_cmd = 1'b0, req_field_sel = 1'b0;
   logic [11:0] req_node_addr = '0;
   logic signed [31:0] req_val_x = '0, req_val_y = '0, req_val_z = '0;
   logic [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [31:0] req_half_x = '0, req_half_y = '0, req_half_z = '0;
   logic rsp_strobe;
   logic signed [31:0] rsp_gathered_x, rsp_gathered_y, rsp_gathered_z;
   logic rsp_out_of_grid, rsp_shape_error;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [4:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   pic_field_gather_3d_core i_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [31:0] elec_store [3*StoreDepth];
   logic [31:0] mag_store  [3*StoreDepth];
   logic [4:0]  node_cnt [3] = '{5'd10, 5'd10, 5'd10};
   logic [31:0] cell_len [3] = '{32'd65536, 32'd65536, 32'd65536};

   gather_beat_type pending_gathers [$];
   int errors = 0, gathers_sent = 0, writes_sent = 0, beats_seen = 0;
   int oog_seen = 0, serr_seen = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   bit accepted_now = 1'b0;

   task automatic report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch on beat %0d: %s got %h want %h", beats_seen, what, got, want);
      errors++;
   endtask

   function automatic logic [63:0] quad_part(logic [63:0] s, logic [63:0] h);
      logic [63:0] r;
      r = (s << FracBits) / h;
      return (r * r) >> (FracBits + 1);
   endfunction

   function automatic logic [63:0] mass_left(logic [63:0] t, logic [63:0] x, logic [63:0] h);
      logic [63:0] one;
      one = 64'd1 << FracBits;
      if (t + h <= x) return 0;
      if (t <= x) return quad_part(t + h - x, h);
      if (t < x + h) return one - quad_part(x + h - t, h);
      return one;
   endfunction

   function automatic logic [63:0] overlap(logic [63:0] x, logic [63:0] h,
                                           logic [63:0] c, longint idx);
      logic [63:0] left, up, dn;
      left = idx * c;
      up = mass_left(left + c, x, h);
      dn = mass_left(left, x, h);
      return up > dn ? up - dn : 0;
   endfunction

   function automatic gather_beat_type gather_field(logic sel, logic [31:0] p [3],
                                                    logic [31:0] hw [3]);
      gather_beat_type res;
      logic [63:0] x [3], h [3], c [3], wx, wxy, w;
      longint cnt [3], home [3], lo [3], hi [3], acc [3], v;
      int node;
      res.oog = 1'b0;
      res.serr = 1'b0;
      acc = '{0, 0, 0};
      for (int a = 0; a < 3; a++) begin
         cnt[a] = node_cnt[a] > MaxNodes ? MaxNodes : node_cnt[a];
         c[a] = cell_len[a] == 0 ? 1 : cell_len[a];
         x[a] = p[a];
         h[a] = hw[a] == 0 ? 1 : hw[a];
         home[a] = x[a] / c[a];
         if (home[a] >= cnt[a]) res.oog = 1'b1;
         if (h[a] > c[a]) res.serr = 1'b1;
         lo[a] = home[a] - 1 < 0 ? 0 : home[a] - 1;
         hi[a] = home[a] + 1 < cnt[a] - 1 ? home[a] + 1 : cnt[a] - 1;
      end
      if (!res.serr) begin
         for (longint i = lo[0]; i <= hi[0]; i++) begin
            wx = overlap(x[0], h[0], c[0], i);
            for (longint j = lo[1]; j <= hi[1]; j++) begin
               wxy = (wx * overlap(x[1], h[1], c[1], j)) >> FracBits;
               for (longint k = lo[2]; k <= hi[2]; k++) begin
                  w = (wxy * overlap(x[2], h[2], c[2], k)) >> FracBits;
                  node = int'((i * MaxNodes + j) * MaxNodes + k);
                  for (int q = 0; q < 3; q++) begin
                     v = sel ? longint'(signed'(mag_store[node*3+q]))
                             : longint'(signed'(elec_store[node*3+q]));
                     acc[q] += (v * longint'(w)) / (longint'(1) << FracBits);
                  end
               end
            end
         end
      end
      for (int q = 0; q < 3; q++) begin
         if (acc[q] > 64'sd2147483647) acc[q] = 64'sd2147483647;
         if (acc[q] < -64'sd2147483648) acc[q] = -64'sd2147483648;
      end
      res.gx = acc[0][31:0];
      res.gy = acc[1][31:0];
      res.gz = acc[2][31:0];
      return res;
   endfunction

   // hold start between beats of a burst; drop it only in a gap
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         burst_left = $urandom_range(1, 12);
         if (gap > 0) begin
            @(negedge clock);
            start = 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   task automatic send_beat(logic cmd, logic sel, logic [11:0] addr,
                            logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                            logic [31:0] p [3], logic [31:0] hw [3]);
      pace();
      @(negedge clock);
      start = 1'b1;
      req_cmd = cmd; req_field_sel = sel; req_node_addr = addr;
      req_val_x = vx; req_val_y = vy; req_val_z = vz;
      req_pos_x = p[0]; req_pos_y = p[1]; req_pos_z = p[2];
      req_half_x = hw[0]; req_half_y = hw[1]; req_half_z = hw[2];
      while (busy) @(negedge clock);
      @(posedge clock);
      accepted_now = 1'b1;
      if (cmd == CmdWrite) begin
         writes_sent++;
         if (sel) {mag_store[addr*3], mag_store[addr*3+1], mag_store[addr*3+2]} = {vx, vy, vz};
         else {elec_store[addr*3], elec_store[addr*3+1], elec_store[addr*3+2]} = {vx, vy, vz};
      end else begin
         gathers_sent++;
         pending_gathers.insert(pending_gathers.size(), gather_field(sel, p, hw));
      end
   endtask

   task automatic write_node(logic sel, logic [11:0] addr, logic [31:0] vx,
                             logic [31:0] vy, logic [31:0] vz);
      logic [31:0] z [3];
      z = '{0, 0, 0};
      send_beat(CmdWrite, sel, addr, vx, vy, vz, z, z);
   endtask

   task automatic gather(logic sel, logic [31:0] p [3], logic [31:0] hw [3]);
      send_beat(CmdGather, sel, 12'($urandom), $urandom, $urandom, $urandom, p, hw);
   endtask

   // wait until every expected beat has come and the core is quiet
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      while (pending_gathers.size() != 0) @(negedge clock);
      while (busy) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
      paddr = 5'(idx * 4); pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      accepted_now = 1'b1;
      case (idx)
         REG_NODES_X: node_cnt[0] = value[4:0];
         REG_NODES_Y: node_cnt[1] = value[4:0];
         REG_NODES_Z: node_cnt[2] = value[4:0];
         REG_CELL_X:  cell_len[0] = value;
         REG_CELL_Y:  cell_len[1] = value;
         REG_CELL_Z:  cell_len[2] = value;
         default: ;
      endcase
      @(negedge clock);
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
   endtask

   task automatic set_grid(logic [31:0] nx, logic [31:0] ny, logic [31:0] nz,
                           logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
      drain();
      csr_write(REG_NODES_X, nx);
      csr_write(REG_NODES_Y, ny);
      csr_write(REG_NODES_Z, nz);
      csr_write(REG_CELL_X, cx);
      csr_write(REG_CELL_Y, cy);
      csr_write(REG_CELL_Z, cz);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fffffff;
         1: return 32'h80000000;
         2: return $urandom_range(0, 32'h0003ffff);
         default: return $urandom;
      endcase
   endfunction

   // a node inside the loaded corner of the grid
   function automatic logic [11:0] pick_node();
      return 12'($urandom_range(0, FillSpan - 1) * MaxNodes * MaxNodes +
                 $urandom_range(0, FillSpan - 1) * MaxNodes +
                 $urandom_range(0, FillSpan - 1));
   endfunction

   // mostly positions inside the grid, with some beyond it
   function automatic logic [31:0] pick_pos(int a);
      logic [63:0] span, c;
      int n;
      n = node_cnt[a] > MaxNodes ? MaxNodes : node_cnt[a];
      c = cell_len[a] == 0 ? 1 : cell_len[a];
      span = c * (n + 1);
      if ($urandom_range(0, 9) == 0 || span > 64'hffffffff) return $urandom;
      return $urandom_range(0, 32'(span));
   endfunction

   function automatic logic [31:0] pick_half(int a);
      logic [31:0] c;
      c = cell_len[a] == 0 ? 1 : cell_len[a];
      case ($urandom_range(0, 11))
         0: return 0;
         1: return c == 32'hffffffff ? c : c + 1 + $urandom_range(0, 100);
         2: return c;
         default: return $urandom_range(1, c);
      endcase
   endfunction

   task automatic random_gathers(int count);
      logic [31:0] p [3], hw [3];
      repeat (count) begin
         if ($urandom_range(0, 4) == 0) begin
            write_node(1'($urandom_range(0, 1)), pick_node(), pick_value(), pick_value(),
                       pick_value());
         end else begin
            for (int a = 0; a < 3; a++) begin
               p[a] = pick_pos(a);
               hw[a] = pick_half(a);
            end
            gather(1'($urandom_range(0, 1)), p, hw);
         end
      end
   endtask

   // load every node that a gather can reach, so none reads an unwritten entry;
   // node counts stay at FillSpan or below unless another axis has no nodes
   task automatic test_fill_grids();
      for (int s = 0; s < 2; s++)
         for (int i = 0; i < FillSpan; i++)
            for (int j = 0; j < FillSpan; j++)
               for (int k = 0; k < FillSpan; k++)
                  write_node(s[0], 12'((i * MaxNodes + j) * MaxNodes + k), pick_value(),
                             pick_value(), pick_value());
   endtask

   task automatic test_directed();
      logic [31:0] p [3], hw [3];
      set_grid(FillSpan, FillSpan, FillSpan, 32'h10000, 32'h10000, 32'h10000);
      p = '{32'h0, 32'h0, 32'h0};            hw = '{32'h8000, 32'h8000, 32'h8000};
      gather(SelElec, p, hw);
      p = '{32'h28000, 32'h18000, 32'h38000}; hw = '{32'h10000, 32'h10000, 32'h10000};
      gather(SelMag, p, hw);
      hw = '{32'h0, 32'h0, 32'h0};            // zero half-width counts as one unit
      gather(SelElec, p, hw);
      hw = '{32'h10001, 32'h1, 32'h1};         // wider than cell
      gather(SelElec, p, hw);
      p = '{32'hffffffff, 32'h20000, 32'h20000}; hw = '{32'h4000, 32'h4000, 32'h4000};
      gather(SelMag, p, hw);                  // far beyond the grid
      p = '{32'h40000, 32'h38000, 32'h30000};
      gather(SelElec, p, hw);                 // home cell just past the edge
      p = '{32'hffffffff, 32'hffffffff, 32'hffffffff}; hw = p;
      gather(SelMag, p, hw);
      // saturation: push the extremes into one neighborhood
      for (int i = 1; i < 4; i++)
         for (int j = 1; j < 4; j++)
            for (int k = 1; k < 4; k++)
               write_node(SelElec, 12'(i*256 + j*16 + k), 32'h7fffffff, 32'h80000000, 32'h7fffffff);
      p = '{32'h28000, 32'h28000, 32'h28000}; hw = '{32'h10000, 32'h10000, 32'h10000};
      gather(SelElec, p, hw);
      p = '{32'h20000, 32'h20000, 32'h20000}; hw = '{32'h1, 32'h1, 32'h1};
      gather(SelElec, p, hw);
   endtask

   task automatic test_config_sweep();
      set_grid(4, 4, 4, 32'h10000, 32'h8000, 32'h18000);
      random_gathers(200);
      set_grid(2, 2, 2, 32'hffffffff, 32'hffffffff, 32'hffffffff);
      random_gathers(100);
      set_grid(31, 0, 5, 0, 1, 32'h3000);
      random_gathers(60);
      set_grid(3, 4, 2, 32'h7, 32'h123456, 32'h80000000);
      random_gathers(120);
      set_grid(FillSpan, FillSpan, FillSpan, 32'h10000, 32'h10000, 32'h10000);
   endtask

   task automatic test_random();
      random_gathers(100);
      drain();                                // sender holds off until all beats are back
      random_gathers(150);
   endtask

   always @(posedge clock) begin
      gather_beat_type want;
      if (!reset && rsp_strobe) begin
         accepted_now = 1'b1;
         beats_seen++;
         if (pending_gathers.size() == 0) begin
            $display("unexpected gather beat %0d", beats_seen);
            errors++;
         end else begin
            want = pending_gathers.pop_front();
            if (rsp_gathered_x !== want.gx) report("gathered_x", rsp_gathered_x, want.gx);
            if (rsp_gathered_y !== want.gy) report("gathered_y", rsp_gathered_y, want.gy);
            if (rsp_gathered_z !== want.gz) report("gathered_z", rsp_gathered_z, want.gz);
            if (rsp_out_of_grid !== want.oog) report("out_of_grid", rsp_out_of_grid, want.oog);
            if (rsp_shape_error !== want.serr) report("shape_error", rsp_shape_error, want.serr);
            oog_seen += want.oog;
            serr_seen += want.serr;
         end
      end
   end

   always @(negedge clock) begin
      if (accepted_now || reset) idle_cycles = 0;
      else idle_cycles++;
      accepted_now = 1'b0;
      if (idle_cycles >= WatchLimit) begin
         $display("timeout: no progress for %0d cycles", WatchLimit);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_fill_grids();
      test_directed();
      test_config_sweep();
      test_random();
      drain();
      repeat (600) @(negedge clock);
      $display("covered %0d node writes and %0d gathers across five grid settings",
               writes_sent, gathers_sent);
      $display("%0d gathers out of grid, %0d shape errors, %0d mismatches",
               oog_seen, serr_seen, errors);
      if (errors == 0 && pending_gathers.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/pfg3d_pkg.sv
rtl/pfg3d_div.sv
rtl/pic_field_gather_3d_core.sv
bench/tb.sv
